// ----- rtl/sfd_pkg.sv -----
// Shared types and constants for the sum-checked frame decoder.
package sfd_pkg;

  localparam int unsigned MaxPayload = 1024;
  localparam logic [11:0] MaxLen     = 12'(MaxPayload);

  // Result queue between parser and output stage; depth must be a power of two.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam logic [QueueAw:0] QueueFull = (QueueAw + 1)'(QueueDepth);

  localparam logic [7:0]  HdrFirstReset  = 8'hA5;
  localparam logic [7:0]  HdrSecondReset = 8'h5A;
  localparam logic [15:0] CheckKeyReset  = 16'h0000;

  localparam logic [7:0]  LenNibbleMask = 8'h0f;
  localparam int unsigned AckReqBit     = 6;
  localparam int unsigned IsAckBit      = 7;
  localparam logic [7:0]  CmdHiMask     = 8'hff >> (8 - 6);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_CHECK_KEY     = 2'd2
  } cfg_idx_e;

  typedef enum logic [11:0] {
    PH_HUNT1  = 12'b0000_0000_0001,
    PH_HUNT2  = 12'b0000_0000_0010,
    PH_ID     = 12'b0000_0000_0100,
    PH_CMD_LO = 12'b0000_0000_1000,
    PH_CMD_HI = 12'b0000_0001_0000,
    PH_RES_LO = 12'b0000_0010_0000,
    PH_RES_HI = 12'b0000_0100_0000,
    PH_LEN_LO = 12'b0000_1000_0000,
    PH_LEN_HI = 12'b0001_0000_0000,
    PH_DATA   = 12'b0010_0000_0000,
    PH_CHK_LO = 12'b0100_0000_0000,
    PH_CHK_HI = 12'b1000_0000_0000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [11:0] payload_index;
    logic [7:0]  packet_id;
    logic [13:0] command_code;
    logic        ack_req;
    logic        is_ack;
    logic [15:0] reserved_word;
    logic [11:0] payload_length;
  } result_t;

endpackage

// ----- rtl/sfd_if.sv -----
// Byte input and result output channel interfaces.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface sfd_out_if import sfd_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  payload_byte;
  logic [11:0] payload_index;
  logic [7:0]  packet_id;
  logic [13:0] command_code;
  logic        ack_req;
  logic        is_ack;
  logic [15:0] reserved_word;
  logic [11:0] payload_length;

  modport source (
    output valid, output kind, output payload_byte, output payload_index,
    output packet_id, output command_code, output ack_req, output is_ack,
    output reserved_word, output payload_length, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input payload_index,
    input packet_id, input command_code, input ack_req, input is_ack,
    input reserved_word, input payload_length, output ready
  );
endinterface

// ----- rtl/sum_checked_frame_decoder.sv -----
// Top level of the sum-checked frame decoder: parser, result queue, output stage.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          data_byte (8)
//   out_ch   out  valid/ready          kind, payload byte/index, frame fields
//   cfg      in   cfg_we_i (no wait)   cfg_idx_i (2), cfg_data_i (16)
//
// One byte per cycle while the queue has room; the parser steps once per byte.
// A result is queued when its byte is accepted, then registered onto out_ch.
// in_ch.ready drops only while the two-entry result queue is full.
// Reset clears all parse state and loads the default header and key values.
module sum_checked_frame_decoder import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfd_in_if.sink      in_ch,
  sfd_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic    q_full, q_valid, q_pop, push;
  result_t push_data, q_data;

  sfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  sfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/sfd_front.sv -----
// Frame parser: takes bytes, tracks header/field/payload/check phases, emits results.
module sfd_front import sfd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfd_in_if.sink        in_ch,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          q_full_i,
  output logic          push_o,
  output result_t       push_data_o
);

  logic [7:0]  hdr_first_q, hdr_second_q;
  logic [15:0] check_key_q;

  phase_e      phase_q, phase_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  check_low_q, check_low_d;
  logic [7:0]  frame_id_q, frame_id_d;
  logic [13:0] frame_cmd_q, frame_cmd_d;
  logic        ack_req_q, ack_req_d;
  logic        is_ack_q, is_ack_d;
  logic [15:0] frame_res_q, frame_res_d;
  logic [11:0] frame_len_q, frame_len_d;
  logic [11:0] taken_q, taken_d;

  logic        accept;
  logic [7:0]  b;
  logic        fail;
  kind_e       kind;
  logic [7:0]  pbyte;
  logic [11:0] pidx;
  logic [15:0] sum_add;
  logic [11:0] len_full;
  logic [11:0] taken_inc;
  logic [15:0] expect_chk;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && !q_full_i;
  assign b           = in_ch.data_byte;
  assign sum_add     = sum_q + {8'd0, b};
  assign len_full    = {b[3:0], frame_len_q[7:0]};
  assign taken_inc   = taken_q + 12'd1;
  assign expect_chk  = (~sum_q) ^ check_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HdrFirstReset;
      hdr_second_q <= HdrSecondReset;
      check_key_q  <= CheckKeyReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data_i[7:0];
        CFG_HEADER_SECOND: hdr_second_q <= cfg_data_i[7:0];
        CFG_CHECK_KEY:     check_key_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    check_low_d = check_low_q;
    frame_id_d  = frame_id_q;
    frame_cmd_d = frame_cmd_q;
    ack_req_d   = ack_req_q;
    is_ack_d    = is_ack_q;
    frame_res_d = frame_res_q;
    frame_len_d = frame_len_q;
    taken_d     = taken_q;
    fail        = 1'b0;
    push_o      = 1'b0;
    kind        = KIND_ERROR;
    pbyte       = 8'd0;
    pidx        = 12'd0;
    if (accept) begin
      unique case (phase_q)
        PH_HUNT1: begin
          sum_d = {8'd0, b};
          if (b == hdr_first_q) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (b == hdr_second_q) begin
            sum_d   = sum_add;
            phase_d = PH_ID;
          end else if (b == hdr_first_q) begin
            // repeated first header: error result, sum restarts, keep waiting
            sum_d  = {8'd0, b};
            push_o = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        PH_ID: begin
          sum_d      = sum_add;
          frame_id_d = b;
          phase_d    = PH_CMD_LO;
        end
        PH_CMD_LO: begin
          sum_d       = sum_add;
          frame_cmd_d = {6'd0, b};
          phase_d     = PH_CMD_HI;
        end
        PH_CMD_HI: begin
          sum_d       = sum_add;
          frame_cmd_d = {6'(b & CmdHiMask), frame_cmd_q[7:0]};
          ack_req_d   = b[AckReqBit];
          is_ack_d    = b[IsAckBit];
          phase_d     = PH_RES_LO;
        end
        PH_RES_LO: begin
          sum_d       = sum_add;
          frame_res_d = {8'd0, b};
          phase_d     = PH_RES_HI;
        end
        PH_RES_HI: begin
          sum_d       = sum_add;
          frame_res_d = {b, frame_res_q[7:0]};
          phase_d     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          sum_d       = sum_add;
          frame_len_d = {4'd0, b};
          phase_d     = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          sum_d = sum_add;
          if ((frame_len_q[7:0] & LenNibbleMask) != {4'd0, b[7:4]}) begin
            fail = 1'b1;
          end else begin
            frame_len_d = len_full;
            if (len_full > MaxLen) begin
              fail = 1'b1;
            end else begin
              taken_d = 12'd0;
              phase_d = (len_full == 12'd0) ? PH_CHK_LO : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          sum_d   = sum_add;
          push_o  = 1'b1;
          kind    = KIND_PAYLOAD;
          pbyte   = b;
          pidx    = taken_q;
          taken_d = taken_inc;
          if (taken_inc == frame_len_q) phase_d = PH_CHK_LO;
        end
        PH_CHK_LO: begin
          check_low_d = b;
          phase_d     = PH_CHK_HI;
        end
        PH_CHK_HI: begin
          if ({b, check_low_q} != expect_chk) begin
            fail = 1'b1;
          end else begin
            phase_d = PH_HUNT1;
            push_o  = 1'b1;
            kind    = KIND_GOOD;
          end
        end
        default: fail = 1'b1;
      endcase
      if (fail) begin
        phase_d = PH_HUNT1;
        sum_d   = 16'd0;
        push_o  = 1'b1;
        kind    = KIND_ERROR;
      end
    end
  end

  // Frame fields report the state as it stands after this byte.
  always_comb begin
    push_data_o.kind           = kind;
    push_data_o.payload_byte   = pbyte;
    push_data_o.payload_index  = pidx;
    push_data_o.packet_id      = frame_id_d;
    push_data_o.command_code   = frame_cmd_d;
    push_data_o.ack_req        = ack_req_d;
    push_data_o.is_ack         = is_ack_d;
    push_data_o.reserved_word  = frame_res_d;
    push_data_o.payload_length = frame_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT1;
      sum_q       <= 16'd0;
      check_low_q <= 8'd0;
      frame_id_q  <= 8'd0;
      frame_cmd_q <= 14'd0;
      ack_req_q   <= 1'b0;
      is_ack_q    <= 1'b0;
      frame_res_q <= 16'd0;
      frame_len_q <= 12'd0;
      taken_q     <= 12'd0;
    end else begin
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      check_low_q <= check_low_d;
      frame_id_q  <= frame_id_d;
      frame_cmd_q <= frame_cmd_d;
      ack_req_q   <= ack_req_d;
      is_ack_q    <= is_ack_d;
      frame_res_q <= frame_res_d;
      frame_len_q <= frame_len_d;
      taken_q     <= taken_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept)
    else $error("result pushed without an accepted byte");

  a_data_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (taken_q < frame_len_q) && (frame_len_q <= MaxLen))
    else $error("payload count outside declared length");

  a_good_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_data_o.kind == KIND_GOOD) |=> (phase_q == PH_HUNT1))
    else $error("good frame did not return to hunting");

  a_error_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_data_o.kind == KIND_ERROR) |=>
      (phase_q == PH_HUNT1 || phase_q == PH_HUNT2))
    else $error("error result left parser inside a frame");
`endif

endmodule

// ----- rtl/sfd_queue.sv -----
// Short result queue between the parser and the output stage.
module sfd_queue import sfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t pop_data_o
);

  result_t            mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q;
  logic               do_pop;

  assign full_o     = (count_q == QueueFull);
  assign valid_o    = (count_q != '0);
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      priority if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sfd_back.sv -----
// Output stage: registers one result from the queue and presents it on the channel.
module sfd_back import sfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  result_t   q_data_i,
  output logic      q_pop_o,
  sfd_out_if.source out_ch
);

  logic    out_valid_q;
  result_t out_data_q;

  // Refill when empty or when the held result is taken this cycle.
  assign q_pop_o = q_valid_i && (!out_valid_q || out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ch.ready) begin
      out_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_data_q <= q_data_i;
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.kind           = out_data_q.kind;
  assign out_ch.payload_byte   = out_data_q.payload_byte;
  assign out_ch.payload_index  = out_data_q.payload_index;
  assign out_ch.packet_id      = out_data_q.packet_id;
  assign out_ch.command_code   = out_data_q.command_code;
  assign out_ch.ack_req        = out_data_q.ack_req;
  assign out_ch.is_ack         = out_data_q.is_ack;
  assign out_ch.reserved_word  = out_data_q.reserved_word;
  assign out_ch.payload_length = out_data_q.payload_length;

endmodule

// ----- verif/tb_sum_checked_frame_decoder.sv -----
// Self-checking testbench for the sum-checked frame decoder: byte stream in, decoded results out.
module tb_sum_checked_frame_decoder;
  import sfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned HoldAfter     = 150;
  localparam int unsigned ReportLimit   = 10;

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_CHECK,
    FAULT_NIBBLE
  } frame_fault_e;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_idx_i  = '0;
  logic [15:0] cfg_data_i = '0;

  logic       drv_valid   = 1'b0;
  logic [7:0] drv_byte    = '0;
  logic       rcv_ready   = 1'b0;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.data_byte = drv_byte;
  assign out_ch.ready    = rcv_ready;

  sum_checked_frame_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Register copies, updated as each write lands.
  logic [7:0]  cfg_hdr_first  = HdrFirstReset;
  logic [7:0]  cfg_hdr_second = HdrSecondReset;
  logic [15:0] cfg_check_key  = CheckKeyReset;

  // Decoder state as the byte stream has been accepted so far.
  phase_e      ph       = PH_HUNT1;
  logic [15:0] sum16    = '0;
  logic [7:0]  chk_lo   = '0;
  logic [7:0]  f_id     = '0;
  logic [13:0] f_cmd    = '0;
  logic [1:0]  f_flags  = '0;
  logic [15:0] f_res    = '0;
  logic [11:0] f_len    = '0;
  logic [11:0] taken    = '0;

  logic [7:0]  stream_q[$];
  result_t     decoded_q[$];
  int unsigned queued     = 0;
  int unsigned mismatches = 0;

  function automatic result_t frame_result(kind_e k, logic [7:0] pb, logic [11:0] pi);
    result_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.payload_index  = pi;
    r.packet_id      = f_id;
    r.command_code   = f_cmd;
    r.ack_req        = f_flags[0];
    r.is_ack         = f_flags[1];
    r.reserved_word  = f_res;
    r.payload_length = f_len;
    return r;
  endfunction

  function automatic void abort_frame();
    decoded_q.push_back(frame_result(KIND_ERROR, '0, '0));
    ph    = PH_HUNT1;
    sum16 = '0;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    case (ph)
      PH_HUNT1: begin
        sum16 = 16'(b);
        if (b == cfg_hdr_first) ph = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == cfg_hdr_second) begin
          sum16 = sum16 + 16'(b);
          ph    = PH_ID;
        end else if (b == cfg_hdr_first) begin
          // stay waiting for the second header byte, push an error, sum restarts here
          sum16 = 16'(b);
          decoded_q.push_back(frame_result(KIND_ERROR, '0, '0));
        end else begin
          abort_frame();
        end
      end
      PH_ID: begin
        sum16 = sum16 + 16'(b);
        f_id  = b;
        ph    = PH_CMD_LO;
      end
      PH_CMD_LO: begin
        sum16 = sum16 + 16'(b);
        f_cmd = 14'(b);
        ph    = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        sum16   = sum16 + 16'(b);
        f_cmd   = {b[5:0], f_cmd[7:0]};
        f_flags = {b[IsAckBit], b[AckReqBit]};
        ph      = PH_RES_LO;
      end
      PH_RES_LO: begin
        sum16 = sum16 + 16'(b);
        f_res = 16'(b);
        ph    = PH_RES_HI;
      end
      PH_RES_HI: begin
        sum16 = sum16 + 16'(b);
        f_res = {b, f_res[7:0]};
        ph    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum16 = sum16 + 16'(b);
        f_len = 12'(b);
        ph    = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum16 = sum16 + 16'(b);
        if (f_len[3:0] != b[7:4]) begin
          abort_frame();
        end else begin
          f_len = {b[3:0], f_len[7:0]};
          if (f_len > MaxLen) begin
            abort_frame();
          end else begin
            taken = '0;
            ph    = (f_len == '0) ? PH_CHK_LO : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        sum16 = sum16 + 16'(b);
        decoded_q.push_back(frame_result(KIND_PAYLOAD, b, taken));
        taken = taken + 12'd1;
        if (taken == f_len) ph = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        chk_lo = b;
        ph     = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        if ({b, chk_lo} != (~sum16 ^ cfg_check_key)) begin
          abort_frame();
        end else begin
          ph = PH_HUNT1;
          decoded_q.push_back(frame_result(KIND_GOOD, '0, '0));
        end
      end
      default: abort_frame();
    endcase
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    stream_q.push_back(b);
    queued++;
  endfunction

  function automatic void push_frame(input logic [7:0] id, cmd_lo, cmd_hi,
                                     input logic [15:0] rsv, input logic [11:0] len,
                                     input frame_fault_e fault);
    logic [7:0]  hdr[9];
    logic [7:0]  len_hi;
    logic [7:0]  pb;
    logic [15:0] sum;
    logic [15:0] chk;
    sum    = '0;
    len_hi = {len[3:0], len[11:8]};
    if (fault == FAULT_NIBBLE) len_hi[7:4] = len[3:0] ^ 4'($urandom_range(1, 15));
    hdr = '{cfg_hdr_first, cfg_hdr_second, id, cmd_lo, cmd_hi, rsv[7:0], rsv[15:8],
            len[7:0], len_hi};
    foreach (hdr[i]) begin
      queue_byte(hdr[i]);
      sum = sum + 16'(hdr[i]);
    end
    // a rejected length ends the frame right after the length bytes
    if (fault != FAULT_NIBBLE && len <= MaxLen) begin
      for (int i = 0; i < int'(len); i++) begin
        pb = 8'($urandom);
        queue_byte(pb);
        sum = sum + 16'(pb);
      end
      chk = ~sum ^ cfg_check_key;
      if (fault == FAULT_CHECK) chk = chk ^ 16'($urandom_range(1, 65535));
      queue_byte(chk[7:0]);
      queue_byte(chk[15:8]);
    end
  endfunction

  function automatic void push_random_frame();
    int unsigned  sel;
    logic [11:0]  len;
    frame_fault_e fault;
    sel = $urandom_range(0, 99);
    if (sel < 55)      len = 12'($urandom_range(0, 6));
    else if (sel < 92) len = 12'($urandom_range(7, 48));
    else               len = 12'($urandom_range(MaxPayload + 1, 4095));
    sel = $urandom_range(0, 99);
    if (sel < 80)      fault = FAULT_NONE;
    else if (sel < 90) fault = FAULT_CHECK;
    else               fault = FAULT_NIBBLE;
    push_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), len, fault);
  endfunction

  function automatic void push_random_chunk();
    int unsigned sel;
    logic [7:0]  b;
    sel = $urandom_range(0, 99);
    if (sel < 72) begin
      push_random_frame();
    end else if (sel < 82) begin
      repeat ($urandom_range(1, 5)) queue_byte(8'($urandom));
    end else if (sel < 90) begin
      b = 8'($urandom);
      if (b == cfg_hdr_second) b = ~b;
      queue_byte(cfg_hdr_first);
      queue_byte(b);
    end else begin
      queue_byte(cfg_hdr_first);
      push_random_frame();
    end
  endfunction

  function automatic void run_random(int unsigned n);
    int unsigned stop;
    stop = queued + n;
    while (queued < stop) push_random_chunk();
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_HEADER_FIRST:  cfg_hdr_first  = val[7:0];
      CFG_HEADER_SECOND: cfg_hdr_second = val[7:0];
      CFG_CHECK_KEY:     cfg_check_key  = val;
      default: ;
    endcase
  endtask

  task automatic set_framing(input logic [7:0] hf, hs, input logic [15:0] key);
    write_reg(CFG_HEADER_FIRST, 16'(hf));
    write_reg(CFG_HEADER_SECOND, 16'(hs));
    write_reg(CFG_CHECK_KEY, key);
  endtask

  // Wait for the stream to go out and every decoded result to come back.
  task automatic drain();
    while (stream_q.size() != 0 || drv_valid || decoded_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Byte driver: bursts of requests separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_byte   <= '0;
      burst_left = $urandom_range(1, 32);
      gap_left   = 0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        predict_byte(drv_byte);
        void'(stream_q.pop_front());
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 32);
        end
      end
      if (drv_valid && !in_ch.ready) begin
        // hold the pending request
      end else if (gap_left != 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (stream_q.size() == 0) begin
        drv_valid <= 1'b0;
      end else begin
        drv_valid <= 1'b1;
        drv_byte  <= stream_q[0];
      end
    end
  end

  // Result monitor and receiver stall pattern.
  int unsigned seen_in;
  int unsigned hold_left;
  int unsigned rx_mode;
  int unsigned mode_left;
  bit          hold_done;

  function automatic string fmt_result(result_t r);
    return $sformatf({"kind=%0d byte=%h idx=%0d id=%h cmd=%h ack_req=%b is_ack=%b",
                      " rsv=%h len=%0d"},
                     r.kind, r.payload_byte, r.payload_index, r.packet_id, r.command_code,
                     r.ack_req, r.is_ack, r.reserved_word, r.payload_length);
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got.kind           = out_ch.kind;
    got.payload_byte   = out_ch.payload_byte;
    got.payload_index  = out_ch.payload_index;
    got.packet_id      = out_ch.packet_id;
    got.command_code   = out_ch.command_code;
    got.ack_req        = out_ch.ack_req;
    got.is_ack         = out_ch.is_ack;
    got.reserved_word  = out_ch.reserved_word;
    got.payload_length = out_ch.payload_length;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit) $display("unexpected result: %s", fmt_result(got));
    end else begin
      want = decoded_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("result mismatch");
          $display("  expected %s", fmt_result(want));
          $display("  actual   %s", fmt_result(got));
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
      seen_in   = 0;
      hold_left = 0;
      rx_mode   = 0;
      mode_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) seen_in++;
      // one long hold while bytes keep coming, so the result queue fills up
      if (!hold_done && seen_in >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else if (rx_mode == 0) begin
        rcv_ready <= 1'b1;
      end else if (rx_mode == 1) begin
        rcv_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        rcv_ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Watchdog on cycles with no request moving on either channel.
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] hf;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: noise while hunting, repeated first header, zero-length frame
    // with all-ones fields, nibble mismatch, oversized length, longest payload.
    queue_byte(~cfg_hdr_first);
    queue_byte(cfg_hdr_first);
    queue_byte(~cfg_hdr_second);
    queue_byte(cfg_hdr_first);
    push_frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 12'd0, FAULT_NONE);
    push_frame(8'h00, 8'h00, 8'h00, 16'h0000, 12'h0A3, FAULT_NIBBLE);
    push_frame(8'h5C, 8'h00, 8'h40, 16'h00FF, 12'hFFF, FAULT_NONE);
    push_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), MaxLen, FAULT_NONE);
    run_random(50);
    drain();

    set_framing(8'h00, 8'hFF, 16'hFFFF);
    run_random(50);
    drain();

    set_framing(8'hFF, 8'h00, 16'h0000);
    run_random(50);
    drain();

    repeat (2) begin
      hf = 8'($urandom);
      set_framing(hf, hf ^ 8'($urandom_range(1, 255)), 16'($urandom));
      run_random(50);
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
